/* hdl/assert_macros.svh */
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Check a property at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/itrm_pkg.sv */
// Types and constants for the IPv4 text range matcher
package itrm_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic        well_formed;
        logic        in_range;
        logic [31:0] address;
    } t_out_word;

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
    } t_parse_res;

    typedef enum logic [1:0] {
        CFG_RANGE_BASE = 2'd0,
        CFG_RANGE_MASK = 2'd1,
        CFG_MATCH_ANY  = 2'd2
    } t_cfg_idx;

    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam logic [7:0]  CHAR_NINE     = 8'h39;
    localparam logic [7:0]  CHAR_DOT      = 8'h2E;
    localparam logic [11:0] SEG_MAX       = 12'd255;
    localparam logic [2:0]  DOTS_FULL     = 3'd3;
    localparam logic [2:0]  DOTS_SAT      = 3'd4;
    localparam logic [1:0]  DIGITS_SAT    = 2'd3;
    localparam logic [31:0] BASE_RESET    = 32'h0000_0000;
    localparam logic [31:0] MASK_RESET    = 32'hFFFF_FFFF;

endpackage

/* hdl/itrm_parser.sv */
// Dotted-quad parser: per-character state update and end-of-text result
module itrm_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  itrm_pkg::t_in_word i_word,
    output itrm_pkg::t_parse_res o_res
);
    import itrm_pkg::*;

    logic [2:0]  r_dots,   n_dots;
    logic [1:0]  r_digits, n_digits;
    logic [7:0]  r_seg,    n_seg;
    logic        r_lzero,  n_lzero;
    logic        r_err,    n_err;
    logic [31:0] r_addr,   n_addr;

    logic        is_digit;
    logic [11:0] seg_mul;

    always_comb begin
        is_digit = (i_word.ch >= CHAR_ZERO) && (i_word.ch <= CHAR_NINE);
        seg_mul  = {1'b0, r_seg, 3'b000} + {3'b000, r_seg, 1'b0}
                 + {8'd0, i_word.ch[3:0]};
        n_dots   = r_dots;
        n_digits = r_digits;
        n_seg    = r_seg;
        n_lzero  = r_lzero;
        n_err    = r_err;
        n_addr   = r_addr;
        unique if (is_digit) begin
            if (r_digits == 2'd0) begin
                n_lzero = (i_word.ch[3:0] == 4'd0);
            end else if (r_lzero) begin
                n_err = 1'b1;
            end
            if (seg_mul > SEG_MAX) begin
                n_seg = SEG_MAX[7:0];
                n_err = 1'b1;
            end else begin
                n_seg = seg_mul[7:0];
            end
            if (r_digits != DIGITS_SAT) begin
                n_digits = r_digits + 2'd1;
            end
        end else if (i_word.ch == CHAR_DOT) begin
            if (r_digits == 2'd0) begin
                n_err = 1'b1;
            end
            if (r_dots >= DOTS_FULL) begin
                n_dots = DOTS_SAT;
                n_err  = 1'b1;
            end else begin
                n_dots = r_dots + 3'd1;
            end
            n_addr   = {r_addr[23:0], r_seg};
            n_digits = 2'd0;
            n_seg    = 8'd0;
            n_lzero  = 1'b0;
        end else begin
            n_err = 1'b1;
        end
        o_res.ok      = !n_err && (n_dots == DOTS_FULL) && (n_digits != 2'd0);
        o_res.address = o_res.ok ? {n_addr[23:0], n_seg} : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_word.last)) begin
            r_dots   <= 3'd0;
            r_digits <= 2'd0;
            r_seg    <= 8'd0;
            r_lzero  <= 1'b0;
            r_err    <= 1'b0;
            r_addr   <= 32'd0;
        end else if (i_take) begin
            r_dots   <= n_dots;
            r_digits <= n_digits;
            r_seg    <= n_seg;
            r_lzero  <= n_lzero;
            r_err    <= n_err;
            r_addr   <= n_addr;
        end
    end

endmodule

/* hdl/ipv4_text_range_matcher_core.sv */
// Top level: IPv4 dotted-quad text parser with network range match
//
// Input channel: one ASCII character per word on i_in_word, with last set
// on the final character of an address. A word is taken when i_in_valid is
// high and o_in_stall is low.
// Output channel: one word per address on o_out_word, valid in the cycle after
// the character that carries last is taken. Taken when o_out_valid is high
// and i_out_stall is low; characters without last give no output word.
// Throughput: one character per cycle while o_in_stall is low. The parse
// state and the result register are each one stage; o_in_stall rises only
// while a result is held in the output register and the receiver stalls it.
// Configuration: i_cfg_wen with i_cfg_idx writes range base, range mask or
// match-any from i_cfg_wdata; write only while idle.
// Reset (synchronous, i_rst_n low): parse state cleared, output invalid,
// base 0, mask all ones, match-any off.
// While the receiver stalls, the output word holds unchanged.
module ipv4_text_range_matcher_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  itrm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output itrm_pkg::t_out_word o_out_word,
    input  logic                i_cfg_wen,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata
);
    import itrm_pkg::*;

    logic [31:0] r_base;
    logic [31:0] r_mask;
    logic        r_any;
    logic        r_out_valid;
    t_out_word   r_out_word;
    t_parse_res  parse_res;
    logic        take;
    logic        hit;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;
    assign hit        = r_any || (parse_res.ok
                        && (((parse_res.address ^ r_base) & r_mask) == 32'd0));

    itrm_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_word  (i_in_word),
        .o_res   (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_mask <= MASK_RESET;
            r_any  <= 1'b0;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RANGE_BASE: r_base <= i_cfg_wdata;
                CFG_RANGE_MASK: r_mask <= i_cfg_wdata;
                CFG_MATCH_ANY:  r_any  <= i_cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_in_word.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_word.last) begin
            r_out_word.well_formed <= parse_res.ok;
            r_out_word.in_range    <= hit;
            r_out_word.address     <= parse_res.address;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* hdl/itrm_checker.sv */
// Port checker for the IPv4 text range matcher, bound to the top level
`include "assert_macros.svh"

module itrm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input itrm_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input itrm_pkg::t_out_word o_out_word
);

    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    `ASSERT_RUN(a_last_gives_word, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_word.last |=> o_out_valid, "no output word after last character")

    `ASSERT_RUN(a_stall_only_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled without a held result")

    `ASSERT_RUN(a_bad_zero_addr, i_clk, i_rst_n, o_out_valid && !o_out_word.well_formed |-> o_out_word.address == 32'd0, "malformed address not zero")

    `ASSERT_RUN(a_hold_stalled, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word), "stalled output word changed")

endmodule

bind ipv4_text_range_matcher_core itrm_checker u_itrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
